/* sv/dual_sorted_task_queue_macros.svh */
// Assertion helpers shared by the queue RTL.
`ifndef DUAL_SORTED_TASK_QUEUE_MACROS_SVH
`define DUAL_SORTED_TASK_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dstq_pkg.sv */
package dstq_pkg;

    // Sizing
    localparam int MAX_TASKS = 16;
    localparam int ID_COUNT  = 16;
    localparam int ID_W      = 4;
    localparam int PRIO_W    = 8;
    localparam int KEY_W     = 16;
    localparam int CNT_W     = 5;
    // A list never holds more distinct ids than exist
    localparam int ORD_DEPTH = (MAX_TASKS < ID_COUNT) ? MAX_TASKS : ID_COUNT;
    localparam int ORD_AW    = $clog2(ORD_DEPTH);

    // Command codes
    localparam logic [1:0] CMD_ADD_PRIO  = 2'd0;
    localparam logic [1:0] CMD_ADD_TIMER = 2'd1;
    localparam logic [1:0] CMD_REM_PRIO  = 2'd2;
    localparam logic [1:0] CMD_REM_TIMER = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    // One list slot: sort key and task id
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Request into a list engine
    typedef struct packed {
        logic             start;
        logic             remove;
        logic             desc;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_list_req;

    // Status out of a list engine
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
        t_entry           head;
    } t_list_stat;

endpackage

/* sv/dstq_if.sv */
// Command channel
interface dstq_cmd_if import dstq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [KEY_W-1:0]  timeout;

    modport source (output valid, command, task_id, priority_req, timeout, input ready);
    modport sink   (input valid, command, task_id, priority_req, timeout, output ready);
endinterface

// Response channel
interface dstq_rsp_if import dstq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             top_valid;
    logic [ID_W-1:0]  top_task;
    logic             next_valid;
    logic [ID_W-1:0]  next_task;
    logic [KEY_W-1:0] next_timeout;
    logic [CNT_W-1:0] prio_occupancy;
    logic [CNT_W-1:0] timer_occupancy;

    modport source (output valid, status, top_valid, top_task, next_valid, next_task,
                    next_timeout, prio_occupancy, timer_occupancy, input ready);
    modport sink   (input valid, status, top_valid, top_task, next_valid, next_task,
                    next_timeout, prio_occupancy, timer_occupancy, output ready);
endinterface

/* sv/dual_sorted_task_queue.sv */
// Channel  | Dir | Words carried
// ---------+-----+-------------------------------------------------------
// i_cmd    | in  | command, task_id, priority_req, timeout
// o_rsp    | out | status, list heads, next_timeout, both occupancies
//
// A list change responds after one pass over the list, one RAM read a cycle
// over its N entries, N at most 16. A rejected command skips the list engine
// and goes straight to the response state. A new command is taken once the
// response is registered; the response register lets it in while a word waits.
// Reset is synchronous, active low, empties both lists.
`include "dual_sorted_task_queue_macros.svh"

module dual_sorted_task_queue import dstq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dstq_cmd_if.sink   i_cmd,
    dstq_rsp_if.source o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [ID_COUNT-1:0] r_in_prio, n_in_prio;
    logic [ID_COUNT-1:0] r_in_timer, n_in_timer;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status;
    logic                r_top_valid;
    logic [ID_W-1:0]     r_top_task;
    logic                r_next_valid;
    logic [ID_W-1:0]     r_next_task;
    logic [KEY_W-1:0]    r_next_timeout;
    logic [CNT_W-1:0]    r_prio_occ;
    logic [CNT_W-1:0]    r_timer_occ;

    logic       accept;
    logic [1:0] chk;
    logic       load;
    t_list_req  p_req, t_req;
    t_list_stat p_stat, t_stat;

    dstq_list u_prio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (p_req),
        .o_stat  (p_stat)
    );

    dstq_list u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (t_req),
        .o_stat  (t_stat)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Command checks against membership and fill
    always_comb begin
        chk = ST_OK;
        case (i_cmd.command)
            CMD_ADD_PRIO: begin
                if (r_in_prio[i_cmd.task_id]) begin
                    chk = ST_DUP;
                end else if (32'(p_stat.count) >= MAX_TASKS) begin
                    chk = ST_FULL;
                end
            end
            CMD_ADD_TIMER: begin
                if (r_in_timer[i_cmd.task_id]) begin
                    chk = ST_DUP;
                end else if (32'(t_stat.count) >= MAX_TASKS) begin
                    chk = ST_FULL;
                end
            end
            CMD_REM_PRIO: begin
                if (!r_in_prio[i_cmd.task_id]) begin
                    chk = ST_ABSENT;
                end
            end
            CMD_REM_TIMER: begin
                if (!r_in_timer[i_cmd.task_id]) begin
                    chk = ST_ABSENT;
                end
            end
            default: chk = ST_OK;
        endcase
    end

    // List engine requests
    always_comb begin
        p_req.start  = accept && (chk == ST_OK) &&
                       ((i_cmd.command == CMD_ADD_PRIO) || (i_cmd.command == CMD_REM_PRIO));
        p_req.remove = (i_cmd.command == CMD_REM_PRIO);
        p_req.desc   = 1'b1;
        p_req.id     = i_cmd.task_id;
        p_req.key    = KEY_W'(i_cmd.priority_req);
        t_req.start  = accept && (chk == ST_OK) &&
                       ((i_cmd.command == CMD_ADD_TIMER) || (i_cmd.command == CMD_REM_TIMER));
        t_req.remove = (i_cmd.command == CMD_REM_TIMER);
        t_req.desc   = 1'b0;
        t_req.id     = i_cmd.task_id;
        t_req.key    = i_cmd.timeout;
    end

    // Sequencer and membership bits
    always_comb begin
        n_state    = r_state;
        n_in_prio  = r_in_prio;
        n_in_timer = r_in_timer;
        n_status   = r_status;
        load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = chk;
                    n_state  = (chk == ST_OK) ? S_BUSY : S_DONE;
                    if (p_req.start) begin
                        n_in_prio[i_cmd.task_id] = !p_req.remove;
                    end
                    if (t_req.start) begin
                        n_in_timer[i_cmd.task_id] = !t_req.remove;
                    end
                end
            end
            S_BUSY: begin
                if (p_stat.done || t_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_prio   <= '0;
            r_in_timer  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_prio   <= n_in_prio;
            r_in_timer  <= n_in_timer;
            r_out_valid <= n_out_valid;
        end
    end

    // Response word; empty lists report zero heads
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (load) begin
            r_out_status   <= r_status;
            r_top_valid    <= (p_stat.count != '0);
            r_top_task     <= (p_stat.count != '0) ? p_stat.head.id : '0;
            r_next_valid   <= (t_stat.count != '0);
            r_next_task    <= (t_stat.count != '0) ? t_stat.head.id : '0;
            r_next_timeout <= (t_stat.count != '0) ? t_stat.head.key : '0;
            r_prio_occ     <= p_stat.count;
            r_timer_occ    <= t_stat.count;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.top_valid       = r_top_valid;
    assign o_rsp.top_task        = r_top_task;
    assign o_rsp.next_valid      = r_next_valid;
    assign o_rsp.next_task       = r_next_task;
    assign o_rsp.next_timeout    = r_next_timeout;
    assign o_rsp.prio_occupancy  = r_prio_occ;
    assign o_rsp.timer_occupancy = r_timer_occ;

    `DSTQ_ASSERT_NOW(a_idle_quiet, r_state == S_IDLE, !p_stat.busy && !t_stat.busy,
        "list engine busy while idle")
    `DSTQ_ASSERT_NOW(a_prio_members, r_state == S_IDLE,
        $countones(r_in_prio) == 32'(p_stat.count), "priority membership out of step")
    `DSTQ_ASSERT_NOW(a_timer_members, r_state == S_IDLE,
        $countones(r_in_timer) == 32'(t_stat.count), "timer membership out of step")

endmodule

/* sv/dstq_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dstq_list.sv */
`include "dual_sorted_task_queue_macros.svh"

// One sorted list in RAM. Insert and remove run as a single pass:
// read slot i while slot i-1 (or i-2) is rewritten with the shifted word.
module dstq_list import dstq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_list_req  i_req,
    output t_list_stat o_stat
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_remove, n_remove;
    logic             r_desc, n_desc;
    logic [ID_W-1:0]  r_id, n_id;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_hit, n_hit;
    t_entry           r_carry, n_carry;
    t_entry           r_head, n_head;

    logic             issue;
    logic             finish;
    logic             later;
    t_entry           rd_word;
    t_entry           new_word;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    t_entry           wr_word;

    dstq_ram #(.WIDTH(ENTRY_W), .DEPTH(ORD_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[ORD_AW-1:0]),
        .i_wr_data (wr_word),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx[ORD_AW-1:0]),
        .o_rd_data (rd_word)
    );

    // Scan control
    assign issue    = r_busy && (r_rd_idx < r_count);
    assign finish   = r_busy && !issue && !r_pend;
    assign new_word = '{key: r_key, id: r_id};
    assign later    = r_desc ? (rd_word.key < r_key) : (rd_word.key > r_key);

    // Next state and RAM writes
    always_comb begin
        n_busy     = r_busy;
        n_done     = 1'b0;
        n_count    = r_count;
        n_remove   = r_remove;
        n_desc     = r_desc;
        n_id       = r_id;
        n_key      = r_key;
        n_rd_idx   = issue ? r_rd_idx + CNT_W'(1) : r_rd_idx;
        n_pend     = issue;
        n_pend_idx = r_rd_idx;
        n_hit      = r_hit;
        n_carry    = r_carry;
        wr_en      = 1'b0;
        wr_idx     = r_pend_idx;
        wr_word    = rd_word;

        if (r_pend) begin
            if (r_remove) begin
                // close the gap left by the removed id
                if (r_hit) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_pend_idx - CNT_W'(1);
                    wr_word = rd_word;
                end else if (rd_word.id == r_id) begin
                    n_hit = 1'b1;
                end
            end else begin
                // after the insert point every word moves up one slot
                if (r_hit) begin
                    wr_en   = 1'b1;
                    wr_word = r_carry;
                    n_carry = rd_word;
                end else if (later) begin
                    wr_en   = 1'b1;
                    wr_word = new_word;
                    n_carry = rd_word;
                    n_hit   = 1'b1;
                end
            end
        end

        if (finish) begin
            if (r_remove) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                wr_en   = 1'b1;
                wr_idx  = r_count;
                wr_word = r_hit ? r_carry : new_word;
                n_count = r_count + CNT_W'(1);
            end
            n_busy = 1'b0;
            n_done = 1'b1;
        end

        if (i_req.start) begin
            n_busy   = 1'b1;
            n_remove = i_req.remove;
            n_desc   = i_req.desc;
            n_id     = i_req.id;
            n_key    = i_req.key;
            n_rd_idx = '0;
            n_pend   = 1'b0;
            n_hit    = 1'b0;
        end

        // keep a copy of slot zero
        n_head = (wr_en && (wr_idx == '0)) ? wr_word : r_head;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
    end

    // Operands and datapath
    always_ff @(posedge i_clk) begin
        r_remove   <= n_remove;
        r_desc     <= n_desc;
        r_id       <= n_id;
        r_key      <= n_key;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_carry    <= n_carry;
        r_head     <= n_head;
    end

    assign o_stat = '{busy: r_busy, done: r_done, count: r_count, head: r_head};

    `DSTQ_ASSERT_NOW(a_count_range, 1'b1, 32'(r_count) <= ORD_DEPTH, "list count over depth")
    `DSTQ_ASSERT_NOW(a_start_idle, i_req.start, !r_busy, "list started while busy")
    `DSTQ_ASSERT_NOW(a_remove_found, finish && r_remove, r_hit, "removed id not in list")
    `DSTQ_ASSERT_NEXT(a_done_ends, finish, r_done && !r_busy, "pass end not flagged")

endmodule
